### hdl/snig_pkg.sv
package snig_pkg;

	localparam int MAX_GRID = 1024;

	localparam int COORD_W = 10;
	localparam int SIZE_W  = 11;
	localparam int KIND_W  = 3;
	localparam int LIN_W   = 21;	// row*n + column
	localparam int PLANE_W = 21;	// n*n
	localparam int IDX_W   = 31;
	localparam int SLOTS   = 8;
	localparam int SLOT_W  = $clog2(SLOTS);

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam int CFG_DATA_W = 11;

	// register indexes
	localparam logic REG_GRID_SIZE = 1'b0;
	localparam logic REG_GRID_KIND = 1'b1;

	// grid kinds
	localparam logic [KIND_W-1:0] KIND_MESH5  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_TORUS5 = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MESH7  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_MESH9  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CUBE   = 3'd4;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] layer;
	} vtx_t;

	typedef struct packed {
		logic [IDX_W-1:0] neighbor_index;
		logic             neighbor_valid;
		logic             last_of_vertex;
		logic             coord_error;
	} nbr_t;

	// static configuration seen by front and back
	typedef struct packed {
		logic [SIZE_W-1:0]  n;
		logic [PLANE_W-1:0] plane;
		logic [KIND_W-1:0]  kind;
	} cfg_t;

	// edge flags: neighbor exists in that direction
	typedef struct packed {
		logic hu;
		logic hd;
		logic hl;
		logic hr;
	} edge_t;

	// classified vertex, one queue entry
	typedef struct packed {
		logic [IDX_W-1:0] base;
		logic [SLOTS-1:0] mask;
		edge_t            edges;
		logic             err;
	} job_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

### hdl/snig_front.sv
module snig_front (
	input  logic           clk,
	input  logic           arst_n,
	input  snig_pkg::cfg_t cfg,
	input  logic           vtx_valid,
	output logic           vtx_stall,
	input  snig_pkg::vtx_t vtx,
	input  logic           q_full,
	output logic           push,
	output snig_pkg::job_t push_job
);
	import snig_pkg::*;

	logic               valid_s1, valid_s2;
	vtx_t               vtx_s1;
	logic               s1_ready, s2_ready;

	logic [LIN_W-1:0]   prod_a, lin;
	logic               row_in, col_in, lay_in, bad_kind, err;
	edge_t              edges;
	logic               hk, hf;

	logic [LIN_W-1:0]   lin_s2;
	logic [COORD_W-1:0] layer_s2;
	edge_t              edges_s2;
	logic               hk_s2, hf_s2, err_s2, bad_s2;

	logic [31:0]        prod_b;
	logic [IDX_W-1:0]   base;
	logic [SLOTS-1:0]   mask;
	logic               diag7, diag9;

	assign s2_ready  = !valid_s2 || !q_full;
	assign s1_ready  = !valid_s1 || s2_ready;
	assign vtx_stall = !s1_ready;
	assign push      = valid_s2 && !q_full;

	// stage 1: range checks, edge flags, row*n + column
	always_comb begin
		row_in   = {1'b0, vtx_s1.row} < cfg.n;
		col_in   = {1'b0, vtx_s1.column} < cfg.n;
		lay_in   = {1'b0, vtx_s1.layer} < cfg.n;
		bad_kind = cfg.kind > KIND_CUBE;
		err      = !row_in || !col_in || (cfg.kind == KIND_CUBE && !lay_in);
		edges.hu = vtx_s1.row != '0;
		edges.hd = ({1'b0, vtx_s1.row} + SIZE_W'(1)) < cfg.n;
		edges.hl = vtx_s1.column != '0;
		edges.hr = ({1'b0, vtx_s1.column} + SIZE_W'(1)) < cfg.n;
		hk       = vtx_s1.layer != '0;
		hf       = ({1'b0, vtx_s1.layer} + SIZE_W'(1)) < cfg.n;
		prod_a   = LIN_W'(vtx_s1.row) * LIN_W'(cfg.n);
		lin      = prod_a + LIN_W'(vtx_s1.column);
	end

	// stage 2: linear base and stencil slot mask
	always_comb begin
		prod_b = 32'(lin_s2) * 32'(cfg.n);
		diag7  = cfg.kind == KIND_MESH7 || cfg.kind == KIND_MESH9;
		diag9  = cfg.kind == KIND_MESH9;
		if (cfg.kind == KIND_CUBE) begin
			base = IDX_W'(prod_b + 32'(layer_s2) + 32'd1);
		end else begin
			base = IDX_W'(lin_s2) + IDX_W'(1);
		end
		if (bad_s2 || err_s2) begin
			mask = '0;
		end else if (cfg.kind == KIND_TORUS5) begin
			mask = 8'h0F;
		end else if (cfg.kind == KIND_CUBE) begin
			mask = {2'b00, hf_s2, hk_s2, edges_s2.hr, edges_s2.hl, edges_s2.hd, edges_s2.hu};
		end else begin
			mask = {diag9 && edges_s2.hd && edges_s2.hl,
				diag9 && edges_s2.hu && edges_s2.hr,
				diag7 && edges_s2.hd && edges_s2.hr,
				diag7 && edges_s2.hu && edges_s2.hl,
				edges_s2.hr, edges_s2.hl, edges_s2.hd, edges_s2.hu};
		end
		push_job.base  = base;
		push_job.mask  = mask;
		push_job.edges = edges_s2;
		push_job.err   = err_s2 && !bad_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= vtx_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready) begin
			vtx_s1 <= vtx;
		end
		if (s2_ready) begin
			lin_s2   <= lin;
			layer_s2 <= vtx_s1.layer;
			edges_s2 <= edges;
			hk_s2    <= hk;
			hf_s2    <= hf;
			err_s2   <= err;
			bad_s2   <= bad_kind;
		end
	end

endmodule

### hdl/snig_queue.sv
module snig_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  snig_pkg::job_t    push_job,
	input  logic              pop,
	output snig_pkg::job_t    head_job,
	output snig_pkg::q_stat_t stat
);
	import snig_pkg::*;

	job_t               mem [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign head_job      = mem[rd_ptr_q];
	assign stat.full     = count_q == Q_CNT_W'(Q_DEPTH);
	assign stat.nonempty = count_q != '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + Q_CNT_W'(1);
				2'b01:   count_q <= count_q - Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/snig_back.sv
module snig_back (
	input  logic              clk,
	input  logic              arst_n,
	input  snig_pkg::cfg_t    cfg,
	input  snig_pkg::job_t    head_job,
	input  snig_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              nbr_valid,
	input  logic              nbr_stall,
	output snig_pkg::nbr_t    nbr
);
	import snig_pkg::*;

	logic              cur_valid_q;
	job_t              cur_q;
	logic              out_valid_q;
	nbr_t              out_q;

	logic              emit, cur_free, last;
	logic [SLOTS-1:0]  sel, rest;
	logic [SLOT_W-1:0] slot;
	logic signed [31:0] sn, sp, delta;
	logic [31:0]       sum;
	nbr_t              res;

	assign nbr_valid = out_valid_q;
	assign nbr       = out_q;

	assign emit     = cur_valid_q && (!out_valid_q || !nbr_stall);
	assign cur_free = !cur_valid_q || (emit && last);
	assign pop      = cur_free && q_stat.nonempty;

	always_comb begin
		sel  = cur_q.mask & (~cur_q.mask + SLOTS'(1));
		rest = cur_q.mask & ~sel;
		last = rest == '0;
		slot = '0;
		for (int s = 0; s < SLOTS; s++) begin
			if (sel[s]) begin
				slot = SLOT_W'(s);
			end
		end
	end

	// offset from the vertex to the neighbor in the selected slot
	always_comb begin
		sn = signed'(32'(cfg.n));
		sp = signed'(32'(cfg.plane));
		case (cfg.kind)
			KIND_TORUS5: begin
				case (slot)
					3'd0:    delta = cur_q.edges.hu ? -sn : sp - sn;
					3'd1:    delta = cur_q.edges.hd ? sn : sn - sp;
					3'd2:    delta = cur_q.edges.hl ? -32'sd1 : sn - 32'sd1;
					default: delta = cur_q.edges.hr ? 32'sd1 : 32'sd1 - sn;
				endcase
			end
			KIND_CUBE: begin
				case (slot)
					3'd0:    delta = -sp;
					3'd1:    delta = sp;
					3'd2:    delta = -sn;
					3'd3:    delta = sn;
					3'd4:    delta = -32'sd1;
					default: delta = 32'sd1;
				endcase
			end
			default: begin
				case (slot)
					3'd0:    delta = -sn;
					3'd1:    delta = sn;
					3'd2:    delta = -32'sd1;
					3'd3:    delta = 32'sd1;
					3'd4:    delta = -sn - 32'sd1;
					3'd5:    delta = sn + 32'sd1;
					3'd6:    delta = 32'sd1 - sn;
					default: delta = sn - 32'sd1;
				endcase
			end
		endcase
		sum = 32'(cur_q.base) + unsigned'(delta);
		if (cur_q.mask == '0) begin
			res.neighbor_index = '0;
			res.neighbor_valid = 1'b0;
			res.coord_error    = cur_q.err;
		end else begin
			res.neighbor_index = IDX_W'(sum);
			res.neighbor_valid = 1'b1;
			res.coord_error    = 1'b0;
		end
		res.last_of_vertex = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (emit && last) begin
				cur_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!nbr_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_job;
		end else if (emit) begin
			cur_q.mask <= rest;
		end
		if (emit) begin
			out_q <= res;
		end
	end

endmodule

### hdl/stencil_neighbor_index_gen.sv
// Stencil neighbor index generator. Each vertex transaction (row, column,
// layer) yields the 1-based linear indices of its stencil neighbors, one result
// transaction per cycle unless stalled, with last_of_vertex set on the last one.
// A 2-D vertex has index row*n+column+1, a 3-D vertex (row*n+column)*n+layer+1.
// grid_kind selects mesh5 / torus5 / mesh7 / mesh9 / cube; grid_size is n,
// clamped to 1..1024. A coordinate at or above n (layer only in cube mode)
// gives one result with neighbor_valid=0 and coord_error=1; a vertex with no
// neighbors or an unused grid kind gives one result with neighbor_valid=0.
// A vertex gives max(1, neighbors) results, at most 8; the back end emits one
// neighbor per cycle while the result channel is not stalled. The front end
// accepts a vertex per cycle unless a full queue backs it up, into a two-stage
// classifier (range check and row*n+column, then base, slot mask and the cube's
// second multiply) that feeds a four-entry queue, so new vertices keep coming
// in while the back end is busy or the result channel is stalled. On the way to
// its first result a vertex passes stages 1 and 2, the queue, cur_q and out_q.
// Configuration is written with cfg_we/cfg_index/cfg_data (index 0 grid_size,
// index 1 grid_kind); the user must write it only while the block is idle,
// which the block does not enforce; n*n is registered the cycle after a write.
module stencil_neighbor_index_gen (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [snig_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                vtx_valid,
	output logic                                vtx_stall,
	input  snig_pkg::vtx_t                      vtx,
	output logic                                nbr_valid,
	input  logic                                nbr_stall,
	output snig_pkg::nbr_t                      nbr
);
	import snig_pkg::*;

	logic [SIZE_W-1:0]  grid_size_q;
	logic [KIND_W-1:0]  grid_kind_q;
	logic [PLANE_W-1:0] plane_q;
	logic [SIZE_W-1:0]  n_eff;
	cfg_t               cfg;

	logic               push, pop;
	job_t               push_job, head_job;
	q_stat_t            q_stat;

	// clamp n into 1..MAX_GRID
	always_comb begin
		if (grid_size_q == '0) begin
			n_eff = SIZE_W'(1);
		end else if (grid_size_q > SIZE_W'(MAX_GRID)) begin
			n_eff = SIZE_W'(MAX_GRID);
		end else begin
			n_eff = grid_size_q;
		end
		cfg.n     = n_eff;
		cfg.plane = plane_q;
		cfg.kind  = grid_kind_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= SIZE_W'(1);
			grid_kind_q <= KIND_MESH5;
			plane_q     <= PLANE_W'(1);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_SIZE: grid_size_q <= cfg_data[SIZE_W-1:0];
					REG_GRID_KIND: grid_kind_q <= cfg_data[KIND_W-1:0];
					default:       grid_kind_q <= grid_kind_q;
				endcase
			end
			plane_q <= PLANE_W'(n_eff) * PLANE_W'(n_eff);
		end
	end

	snig_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx       (vtx),
		.q_full    (q_stat.full),
		.push      (push),
		.push_job  (push_job)
	);

	snig_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (q_stat)
	);

	snig_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head_job  (head_job),
		.q_stat    (q_stat),
		.pop       (pop),
		.nbr_valid (nbr_valid),
		.nbr_stall (nbr_stall),
		.nbr       (nbr)
	);

endmodule

### bench/stencil_neighbor_index_gen_chk.sv
`timescale 1ns / 1ps

module stencil_neighbor_index_gen_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [snig_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            vtx_valid,
	input  logic                            vtx_stall,
	input  snig_pkg::vtx_t                  vtx,
	input  logic                            nbr_valid,
	input  logic                            nbr_stall,
	input  snig_pkg::nbr_t                  nbr,
	output int                              due_count,
	output int                              fail_count
);
	import snig_pkg::*;

	logic [SIZE_W-1:0] grid_n_reg;
	logic [KIND_W-1:0] grid_kind_reg;
	nbr_t              nbr_due[$];
	nbr_t              due;

	function automatic nbr_t make_nbr(longint idx, bit ok, bit last, bit err);
		nbr_t r;
		r.neighbor_index = idx[IDX_W-1:0];
		r.neighbor_valid = ok;
		r.last_of_vertex = last;
		r.coord_error    = err;
		return r;
	endfunction

	function automatic void note_mismatch(string what, nbr_t exp_r, nbr_t got_r);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t mismatch (%s): exp idx=%0d v=%0b l=%0b e=%0b got idx=%0d v=%0b l=%0b e=%0b",
				$realtime, what, exp_r.neighbor_index, exp_r.neighbor_valid,
				exp_r.last_of_vertex, exp_r.coord_error, got_r.neighbor_index,
				got_r.neighbor_valid, got_r.last_of_vertex, got_r.coord_error);
	endfunction

	// queue up the neighbor transactions one vertex must produce
	function automatic void predict_neighbors(vtx_t v);
		longint n, i, j, k, base, plane;
		longint hits[$];
		bit     hu, hd, hl, hr;
		n = (grid_n_reg == 0) ? 1 : ((grid_n_reg > MAX_GRID) ? MAX_GRID : grid_n_reg);
		i = v.row;
		j = v.column;
		k = v.layer;
		if (grid_kind_reg > KIND_CUBE) begin
			nbr_due.push_back(make_nbr(0, 0, 1, 0));
			return;
		end
		if (i >= n || j >= n || (grid_kind_reg == KIND_CUBE && k >= n)) begin
			nbr_due.push_back(make_nbr(0, 0, 1, 1));
			return;
		end
		hu = i > 0;
		hd = i < n - 1;
		hl = j > 0;
		hr = j < n - 1;
		if (grid_kind_reg == KIND_CUBE) begin
			base  = (i * n + j) * n + k + 1;
			plane = n * n;
			if (hu) hits.push_back(base - plane);
			if (hd) hits.push_back(base + plane);
			if (hl) hits.push_back(base - n);
			if (hr) hits.push_back(base + n);
			if (k > 0) hits.push_back(base - 1);
			if (k < n - 1) hits.push_back(base + 1);
		end else if (grid_kind_reg == KIND_TORUS5) begin
			// wraps at every border, so always four
			hits.push_back((hu ? i - 1 : n - 1) * n + j + 1);
			hits.push_back((hd ? i + 1 : 0) * n + j + 1);
			hits.push_back(i * n + (hl ? j - 1 : n - 1) + 1);
			hits.push_back(i * n + (hr ? j + 1 : 0) + 1);
		end else begin
			if (hu) hits.push_back((i - 1) * n + j + 1);
			if (hd) hits.push_back((i + 1) * n + j + 1);
			if (hl) hits.push_back(i * n + j);
			if (hr) hits.push_back(i * n + j + 2);
			if (grid_kind_reg == KIND_MESH7 || grid_kind_reg == KIND_MESH9) begin
				if (hu && hl) hits.push_back((i - 1) * n + j);
				if (hd && hr) hits.push_back((i + 1) * n + j + 2);
			end
			if (grid_kind_reg == KIND_MESH9) begin
				if (hu && hr) hits.push_back((i - 1) * n + j + 2);
				if (hd && hl) hits.push_back((i + 1) * n + j);
			end
		end
		if (hits.size() == 0)
			nbr_due.push_back(make_nbr(0, 0, 1, 0));
		else
			foreach (hits[q])
				nbr_due.push_back(make_nbr(hits[q], 1, q == hits.size() - 1, 0));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_n_reg    = 1;
			grid_kind_reg = KIND_MESH5;
			nbr_due.delete();
			fail_count    = 0;
			due_count     = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_GRID_SIZE)
					grid_n_reg = cfg_data;
				else
					grid_kind_reg = cfg_data[KIND_W-1:0];
			end
			if (nbr_valid && !nbr_stall) begin
				if (nbr_due.size() == 0) begin
					note_mismatch("unexpected", make_nbr(0, 0, 0, 0), nbr);
				end else begin
					due = nbr_due.pop_front();
					if (nbr.neighbor_index !== due.neighbor_index ||
					    nbr.neighbor_valid !== due.neighbor_valid ||
					    nbr.last_of_vertex !== due.last_of_vertex ||
					    nbr.coord_error !== due.coord_error)
						note_mismatch("field", due, nbr);
				end
			end
			if (vtx_valid && !vtx_stall)
				predict_neighbors(vtx);
			due_count = nbr_due.size();
		end
	end

endmodule

### bench/stencil_neighbor_index_gen_tb.sv
`timescale 1ns / 1ps

module stencil_neighbor_index_gen_tb;
	import snig_pkg::*;

	// grid kinds the block does not implement
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
	// cycles with no transaction on either channel before giving up
	localparam int QUIET_LIMIT = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  vtx_valid;
	logic                  vtx_stall;
	vtx_t                  vtx;
	logic                  nbr_valid;
	logic                  nbr_stall;
	nbr_t                  nbr;

	int due_count;
	int fail_count;
	int quiet_cycles = 0;

	// shared between sender and receiver processes
	bit no_gaps = 0;		// both sides run without idle cycles
	int hold_cycles = 0;	// one-shot long stall request for the receiver

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	stencil_neighbor_index_gen u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx       (vtx),
		.nbr_valid (nbr_valid),
		.nbr_stall (nbr_stall),
		.nbr       (nbr)
	);

	stencil_neighbor_index_gen_chk u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.vtx_valid  (vtx_valid),
		.vtx_stall  (vtx_stall),
		.vtx        (vtx),
		.nbr_valid  (nbr_valid),
		.nbr_stall  (nbr_stall),
		.nbr        (nbr),
		.due_count  (due_count),
		.fail_count (fail_count)
	);

	// Watchdog: a hung channel or a lost result shows up as a long quiet stretch.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((vtx_valid && !vtx_stall) || (nbr_valid && !nbr_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Result side: random stall before each transaction, plus the one long hold
	// that backs the block up until it stalls its vertex input.
	initial begin
		int gap;
		nbr_stall <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				nbr_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end else begin
				gap = no_gaps ? 0 : $urandom_range(0, 3);
				if (gap > 0) begin
					nbr_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
			end
			nbr_stall <= 1'b0;
			do @(posedge clk); while (!nbr_valid);
		end
	end

	// Called at a clock edge; returns at the edge where the vertex is taken.
	task automatic offer_vertex(input int r, input int c, input int l);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			vtx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx_valid  <= 1'b1;
		vtx.row    <= r[COORD_W-1:0];
		vtx.column <= c[COORD_W-1:0];
		vtx.layer  <= l[COORD_W-1:0];
		do @(posedge clk); while (vtx_stall);
	endtask

	// Sender goes quiet until every outstanding neighbor transaction is back.
	task automatic drain_results();
		vtx_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// Only ever called with the block idle; n*n settles in the cycle after the write.
	task automatic set_grid(input int size, input logic [KIND_W-1:0] kind);
		drain_results();
		write_reg(REG_GRID_SIZE, size);
		write_reg(REG_GRID_KIND, kind);
		repeat (2) @(posedge clk);
	endtask

	// Coordinate biased toward the grid border, sometimes outside the grid.
	function automatic int pick_coord(int side);
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0 && side <= 1023)
			return $urandom_range(side, 1023);
		if (roll <= 2)
			return 0;
		if (roll <= 4)
			return side - 1;
		return $urandom_range(0, side - 1);
	endfunction

	initial begin
		int size_sel;
		int grid_size;
		int side;
		logic [KIND_W-1:0] kind;
		int kind_sel;

		cfg_we    <= 1'b0;
		cfg_index <= REG_GRID_SIZE;
		cfg_data  <= '0;
		vtx_valid <= 1'b0;
		vtx       <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// --- directed part ---
		// reset settings: single-point mesh, no neighbors at all
		offer_vertex(0, 0, 0);

		// small mesh9: corners, interior, out-of-range row and column
		set_grid(4, KIND_MESH9);
		offer_vertex(0, 0, 0);
		offer_vertex(1, 2, 0);
		offer_vertex(3, 3, 1023);
		offer_vertex(4, 0, 0);
		offer_vertex(0, 1023, 0);

		// torus with two points per side repeats indices; one point wraps onto itself
		set_grid(2, KIND_TORUS5);
		offer_vertex(0, 0, 0);
		offer_vertex(1, 1, 0);
		set_grid(1, KIND_TORUS5);
		offer_vertex(0, 0, 0);

		// largest cube: far corner hits the top of the index range
		set_grid(MAX_GRID, KIND_CUBE);
		offer_vertex(1023, 1023, 1023);
		offer_vertex(0, 0, 0);
		offer_vertex(512, 511, 3);

		// layer is range checked in cube mode only
		set_grid(3, KIND_CUBE);
		offer_vertex(0, 0, 3);
		offer_vertex(1, 1, 1);

		set_grid(5, KIND_MESH7);
		offer_vertex(2, 2, 1023);
		offer_vertex(0, 4, 0);

		// unimplemented kind ignores coordinates entirely
		set_grid(5, KIND_SPARE_HI);
		offer_vertex(1023, 1023, 1023);

		// size zero acts as one
		set_grid(0, KIND_MESH7);
		offer_vertex(0, 0, 0);
		offer_vertex(1, 0, 0);

		// oversize clamps to the maximum grid
		set_grid(2047, KIND_MESH5);
		offer_vertex(1023, 0, 1023);
		offer_vertex(0, 1023, 0);

		// --- random part: ten settings, fifteen vertices each ---
		for (int phase = 0; phase < 10; phase++) begin
			size_sel = $urandom_range(0, 9);
			case (size_sel)
				0:       grid_size = 0;
				1:       grid_size = 1;
				2:       grid_size = 2;
				7:       grid_size = MAX_GRID;
				8:       grid_size = $urandom_range(MAX_GRID + 1, 2047);
				9:       grid_size = $urandom_range(13, 1023);
				default: grid_size = $urandom_range(3, 12);
			endcase
			kind_sel = $urandom_range(0, 9);
			kind = (kind_sel < 8) ? kind_sel[KIND_W-1:0] : KIND_CUBE;
			if (phase == 3)
				kind = KIND_MESH9;	// many results per vertex for the backpressure phase
			set_grid(grid_size, kind);
			side = (grid_size == 0) ? 1 : ((grid_size > MAX_GRID) ? MAX_GRID : grid_size);

			// phase 3: result side holds off a long time while vertices keep coming
			no_gaps = (phase == 3 || phase == 6);
			if (phase == 3)
				hold_cycles = 80;

			for (int n_item = 0; n_item < 15; n_item++) begin
				if (kind == KIND_CUBE)
					offer_vertex(pick_coord(side), pick_coord(side), pick_coord(side));
				else if (kind >= KIND_SPARE_LO)
					offer_vertex($urandom_range(0, 1023), $urandom_range(0, 1023),
						$urandom_range(0, 1023));
				else
					offer_vertex(pick_coord(side), pick_coord(side), $urandom_range(0, 1023));
			end
		end
		no_gaps = 0;

		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### stencil_neighbor_index_gen.f
hdl/snig_pkg.sv
hdl/snig_front.sv
hdl/snig_queue.sv
hdl/snig_back.sv
hdl/stencil_neighbor_index_gen.sv
bench/stencil_neighbor_index_gen_chk.sv
bench/stencil_neighbor_index_gen_tb.sv
